@@ design/sxc_pkg.sv @@
package sxc_pkg;

  localparam int DOUBLE_ROUNDS = 10;
  localparam int BLOCK_BYTES   = 64;
  localparam int POS_W         = $clog2(BLOCK_BYTES);
  localparam int BLOCK_W       = BLOCK_BYTES * 8;

  // Each double round takes four steps: two half quarter-rounds for the
  // column round and two for the row round.
  localparam int STEPS  = DOUBLE_ROUNDS * 4;
  localparam int STEP_W = $clog2(STEPS);

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [31:0] SIG0 = 32'h61707865;
  localparam logic [31:0] SIG1 = 32'h3320646e;
  localparam logic [31:0] SIG2 = 32'h79622d32;
  localparam logic [31:0] SIG3 = 32'h6b206574;

  // Word indexes a, b, c, d of the four quarter-rounds, column round first.
  localparam logic [3:0] QIDX [2][4][4] = '{
    '{'{4'd0, 4'd4, 4'd8, 4'd12}, '{4'd5, 4'd9, 4'd13, 4'd1},
      '{4'd10, 4'd14, 4'd2, 4'd6}, '{4'd15, 4'd3, 4'd7, 4'd11}},
    '{'{4'd0, 4'd1, 4'd2, 4'd3}, '{4'd5, 4'd6, 4'd7, 4'd4},
      '{4'd10, 4'd11, 4'd8, 4'd9}, '{4'd15, 4'd12, 4'd13, 4'd14}}
  };

  typedef enum logic [2:0] {
    REG_KEY0  = 3'd0,
    REG_KEY1  = 3'd1,
    REG_KEY2  = 3'd2,
    REG_KEY3  = 3'd3,
    REG_NONCE = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic       first;
    logic [7:0] data;
  } q_item_t;

  typedef struct packed {
    logic    vld;
    q_item_t item;
  } q_head_t;

  typedef struct packed {
    logic        take;
    logic [31:0] target;
  } ks_req_t;

  typedef struct packed {
    logic        vld;
    logic [31:0] ctr;
  } ks_stat_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

endpackage

@@ design/sxc_front.sv @@
module sxc_front import sxc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       first_i,
  input  logic       pop_i,
  output q_head_t    head_o
);

  q_item_t          mem_q [QDEPTH];
  logic [QAW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QAW:0]     cnt_q, cnt_d;
  logic             push;
  logic             pop;

  assign in_stall_o = (cnt_q == (QAW+1)'(QDEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && (cnt_q != '0);

  assign head_o.vld  = (cnt_q != '0);
  assign head_o.item = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{first: first_i, data: data_byte_i};
    end
  end

endmodule

@@ design/sxc_core.sv @@
module sxc_core import sxc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [63:0]        cfg_data_i,
  input  ks_req_t            req_i,
  output ks_stat_t           stat_o,
  output logic [BLOCK_W-1:0] block_o
);

  typedef enum logic [1:0] {
    G_IDLE,
    G_RUN,
    G_ADD
  } gen_state_e;

  gen_state_e         state_q;
  logic [STEP_W-1:0]  step_q;
  logic [31:0]        gen_ctr_q;
  logic               res_vld_q;
  logic [31:0]        res_ctr_q;
  logic [BLOCK_W-1:0] res_q;
  logic [31:0]        w_q [16];
  logic [31:0]        w_d [16];
  logic [31:0]        init_w [16];
  logic [63:0]        key0_q, key1_q, key2_q, key3_q, nonce_q;
  logic               start;
  logic               abort;
  logic               last_step;

  assign stat_o.vld = res_vld_q;
  assign stat_o.ctr = res_ctr_q;
  assign block_o    = res_q;

  assign last_step = (step_q == STEP_W'(STEPS - 1));
  // A key change drops any block made or in flight; a changed demand
  // restarts the generator on the block now wanted.
  assign abort = cfg_we_i || ((state_q == G_RUN) && (gen_ctr_q != req_i.target));
  assign start = (state_q == G_IDLE) && !cfg_we_i &&
                 !(res_vld_q && (res_ctr_q == req_i.target));

  always_comb begin
    init_w[0]  = SIG0;
    init_w[1]  = key0_q[31:0];
    init_w[2]  = key0_q[63:32];
    init_w[3]  = key1_q[31:0];
    init_w[4]  = key1_q[63:32];
    init_w[5]  = SIG1;
    init_w[6]  = nonce_q[31:0];
    init_w[7]  = nonce_q[63:32];
    init_w[8]  = gen_ctr_q;
    init_w[9]  = '0;
    init_w[10] = SIG2;
    init_w[11] = key2_q[31:0];
    init_w[12] = key2_q[63:32];
    init_w[13] = key3_q[31:0];
    init_w[14] = key3_q[63:32];
    init_w[15] = SIG3;
  end

  // Half a quarter-round per cycle on all four quarters at once.
  always_comb begin
    logic       half;
    logic [3:0] ia, ib, ic, id;
    logic [31:0] t0, t1;
    half = step_q[1];
    w_d  = w_q;
    for (int q = 0; q < 4; q++) begin
      ia = QIDX[half][q][0];
      ib = QIDX[half][q][1];
      ic = QIDX[half][q][2];
      id = QIDX[half][q][3];
      if (!step_q[0]) begin
        t0 = w_q[ib] ^ rotl(w_q[ia] + w_q[id], 7);
        t1 = w_q[ic] ^ rotl(t0 + w_q[ia], 9);
        w_d[ib] = t0;
        w_d[ic] = t1;
      end else begin
        t0 = w_q[id] ^ rotl(w_q[ic] + w_q[ib], 13);
        t1 = w_q[ia] ^ rotl(t0 + w_q[ic], 18);
        w_d[id] = t0;
        w_d[ia] = t1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q  <= '0;
      key1_q  <= '0;
      key2_q  <= '0;
      key3_q  <= '0;
      nonce_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KEY0:  key0_q  <= cfg_data_i;
        REG_KEY1:  key1_q  <= cfg_data_i;
        REG_KEY2:  key2_q  <= cfg_data_i;
        REG_KEY3:  key3_q  <= cfg_data_i;
        REG_NONCE: nonce_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= G_IDLE;
      step_q    <= '0;
      gen_ctr_q <= '0;
      res_vld_q <= 1'b0;
    end else begin
      if ((state_q == G_ADD) && !cfg_we_i) begin
        res_vld_q <= 1'b1;
      end else if (req_i.take || cfg_we_i) begin
        res_vld_q <= 1'b0;
      end
      case (state_q)
        G_IDLE: begin
          if (start) begin
            state_q   <= G_RUN;
            step_q    <= '0;
            gen_ctr_q <= req_i.target;
          end
        end
        G_RUN: begin
          if (abort) begin
            state_q <= G_IDLE;
          end else if (last_step) begin
            state_q <= G_ADD;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        G_ADD: begin
          state_q <= G_IDLE;
        end
        default: state_q <= G_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      for (int i = 0; i < 16; i++) begin
        w_q[i] <= (i == 8) ? req_i.target : init_w[i];
      end
    end else if (state_q == G_RUN) begin
      w_q <= w_d;
    end
    if (state_q == G_ADD) begin
      res_ctr_q <= gen_ctr_q;
      for (int i = 0; i < 16; i++) begin
        res_q[32*i +: 32] <= w_q[i] + init_w[i];
      end
    end
  end

endmodule

@@ design/sxc_back.sv @@
module sxc_back import sxc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  q_head_t            head_i,
  output logic               pop_o,
  input  ks_stat_t           stat_i,
  input  logic [BLOCK_W-1:0] block_i,
  output ks_req_t            req_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_byte_o
);

  logic [BLOCK_W-1:0] ks_q;
  logic               cur_vld_q;
  logic [POS_W-1:0]   pos_q;
  logic [31:0]        ctr_q;
  logic               out_vld_q;
  logic [7:0]         out_byte_q;
  logic [31:0]        e_ctr;
  logic [POS_W-1:0]   e_pos;
  logic [POS_W-1:0]   pos_n;
  logic               have;
  logic               hit;
  logic               fire;
  logic [7:0]         ks_byte;

  // A new message may reuse the buffered block only if it is block zero
  // and untouched.
  assign e_ctr = head_i.item.first ? '0 : ctr_q;
  assign e_pos = head_i.item.first ? '0 : pos_q;
  assign have  = head_i.item.first ? (cur_vld_q && (ctr_q == '0) && (pos_q == '0))
                                   : cur_vld_q;
  assign hit   = stat_i.vld && (stat_i.ctr == e_ctr);
  assign fire  = head_i.vld && (have || hit) && (!out_vld_q || !out_stall_i);
  assign pos_n = e_pos + 1'b1;

  assign ks_byte     = have ? ks_q[7:0] : block_i[7:0];
  assign pop_o       = fire;
  assign req_o.take  = fire && !have;
  assign req_o.target = (head_i.vld && !have) ? e_ctr
                                              : (cur_vld_q ? ctr_q + 1'b1 : ctr_q);

  assign out_valid_o = out_vld_q;
  assign out_byte_o  = out_byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      pos_q     <= '0;
      ctr_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (fire) begin
        out_vld_q <= 1'b1;
        pos_q     <= pos_n;
        cur_vld_q <= (pos_n != '0);
        ctr_q     <= (pos_n == '0) ? e_ctr + 1'b1 : e_ctr;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_byte_q <= head_i.item.data ^ ks_byte;
      ks_q       <= have ? (ks_q >> 8) : (block_i >> 8);
    end
  end

endmodule

@@ design/salsa20_stream_xor_core.sv @@
// Accepted bytes wait in the input queue and are XORed with keystream into the registered
// output byte. One byte per cycle inside a message while keystream is ready and output is not
// stalled; the core prefetches the next block by a load, 40 half quarter-round steps and a
// final add. A first flag or a key change may stall input while block 0 is made.
// Reset (rst_ni low, asynchronous) clears key registers, counters, queue pointers, valid flags.
module salsa20_stream_xor_core import sxc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o
);

  q_head_t            head;
  logic               pop;
  ks_req_t            req;
  ks_stat_t           stat;
  logic [BLOCK_W-1:0] block;

  sxc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .first_i     (first_i),
    .pop_i       (pop),
    .head_o      (head)
  );

  sxc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req),
    .stat_o     (stat),
    .block_o    (block)
  );

  sxc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .stat_i      (stat),
    .block_i     (block),
    .req_o       (req),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o)
  );

endmodule
